@@ src/bls_pkg.sv @@
// shared types and constants of the bresenham line stepper
package bls_pkg;

  // coordinate and error widths
  localparam int CoordBits = 12;
  localparam int ErrBits   = 14;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic        [CoordBits-1:0] mag_t;
  typedef logic signed [ErrBits-1:0]   err_t;

  // item opcodes
  typedef enum logic {
    OpLoad = 1'b0,
    OpStep = 1'b1
  } op_e;

  // input item
  typedef struct packed {
    op_e    op;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } in_item_t;

  // result item
  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   last_pixel;
  } out_item_t;

  // classified command, with the line setup already worked out for loads
  typedef struct packed {
    op_e    op;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    mag_t   delta_x;
    mag_t   delta_y_mag;
    logic   step_x_neg;
    logic   step_y_neg;
    err_t   error_init;
  } cmd_t;

  // command queue status
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ src/bls_front.sv @@
// front end: accepts items and computes line setup for loads
module bls_front (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bls_pkg::in_item_t in_item_i,
  input  bls_pkg::q_stat_t  q_stat_i,
  output logic              push_o,
  output bls_pkg::cmd_t     cmd_o
);

  logic signed [bls_pkg::CoordBits:0] diff_x;
  logic signed [bls_pkg::CoordBits:0] diff_y;
  logic signed [bls_pkg::CoordBits:0] abs_x;
  logic signed [bls_pkg::CoordBits:0] abs_y;

  // accept whenever the queue has room
  assign in_stall_o = q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full;

  // signed distances on both axes
  always_comb begin
    diff_x = $signed({in_item_i.end_x[bls_pkg::CoordBits-1], in_item_i.end_x})
           - $signed({in_item_i.start_x[bls_pkg::CoordBits-1], in_item_i.start_x});
    diff_y = $signed({in_item_i.end_y[bls_pkg::CoordBits-1], in_item_i.end_y})
           - $signed({in_item_i.start_y[bls_pkg::CoordBits-1], in_item_i.start_y});
    abs_x  = diff_x[bls_pkg::CoordBits] ? -diff_x : diff_x;
    abs_y  = diff_y[bls_pkg::CoordBits] ? -diff_y : diff_y;
  end

  // build the command
  always_comb begin
    cmd_o.op          = in_item_i.op;
    cmd_o.start_x     = in_item_i.start_x;
    cmd_o.start_y     = in_item_i.start_y;
    cmd_o.end_x       = in_item_i.end_x;
    cmd_o.end_y       = in_item_i.end_y;
    cmd_o.delta_x     = abs_x[bls_pkg::CoordBits-1:0];
    cmd_o.delta_y_mag = abs_y[bls_pkg::CoordBits-1:0];
    // equal coordinates step negative, never taken
    cmd_o.step_x_neg  = !(in_item_i.start_x < in_item_i.end_x);
    cmd_o.step_y_neg  = !(in_item_i.start_y < in_item_i.end_y);
    cmd_o.error_init  = $signed({2'b00, abs_x[bls_pkg::CoordBits-1:0]})
                      - $signed({2'b00, abs_y[bls_pkg::CoordBits-1:0]});
  end

endmodule

@@ src/bls_cmd_queue.sv @@
// short command queue between the front and back ends
module bls_cmd_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  bls_pkg::cmd_t    push_cmd_i,
  input  logic             pop_i,
  output bls_pkg::cmd_t    head_o,
  output bls_pkg::q_stat_t stat_o
);

  localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  bls_pkg::cmd_t   mem_q [DEPTH];
  logic [IdxW-1:0] wr_ptr_q, wr_ptr_d;
  logic [IdxW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign stat_o.full  = (count_q == CntW'(DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign head_o       = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == IdxW'(DEPTH - 1)) ? '0 : wr_ptr_q + IdxW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == IdxW'(DEPTH - 1)) ? '0 : rd_ptr_q + IdxW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

@@ src/bls_back.sv @@
// back end: holds the line state, steps it and registers the pixel
module bls_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bls_pkg::cmd_t      head_i,
  input  bls_pkg::q_stat_t   q_stat_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bls_pkg::out_item_t out_item_o
);

  localparam int EW = bls_pkg::ErrBits + 1;

  bls_pkg::coord_t cur_x_q, cur_x_d;
  bls_pkg::coord_t cur_y_q, cur_y_d;
  bls_pkg::coord_t target_x_q, target_x_d;
  bls_pkg::coord_t target_y_q, target_y_d;
  bls_pkg::mag_t   delta_x_q, delta_x_d;
  bls_pkg::mag_t   delta_y_mag_q, delta_y_mag_d;
  logic            step_x_neg_q, step_x_neg_d;
  logic            step_y_neg_q, step_y_neg_d;
  bls_pkg::err_t   error_term_q, error_term_d;
  logic            line_active_q, line_active_d;

  logic               out_valid_q, out_valid_d;
  bls_pkg::out_item_t out_item_q, out_item_d;

  logic              out_free;
  logic              at_end;
  logic signed [EW-1:0] e2;
  logic              move_x;
  logic              move_y;
  bls_pkg::err_t     err_dx;
  bls_pkg::err_t     err_dy;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // output register may take a new pixel
  assign out_free = !out_valid_q || !out_stall_i;

  // loads never need the output register
  assign pop_o = !q_stat_i.empty && ((head_i.op == bls_pkg::OpLoad) || out_free);

  // doubled-error tests
  always_comb begin
    at_end = (cur_x_q == target_x_q) && (cur_y_q == target_y_q);
    e2     = {error_term_q, 1'b0};
    move_x = (e2 >= -$signed({3'b000, delta_y_mag_q}));
    move_y = (e2 <= $signed({3'b000, delta_x_q}));
    err_dy = move_x ? $signed({2'b00, delta_y_mag_q}) : '0;
    err_dx = move_y ? $signed({2'b00, delta_x_q}) : '0;
  end

  // command execution
  always_comb begin
    cur_x_d       = cur_x_q;
    cur_y_d       = cur_y_q;
    target_x_d    = target_x_q;
    target_y_d    = target_y_q;
    delta_x_d     = delta_x_q;
    delta_y_mag_d = delta_y_mag_q;
    step_x_neg_d  = step_x_neg_q;
    step_y_neg_d  = step_y_neg_q;
    error_term_d  = error_term_q;
    line_active_d = line_active_q;
    out_item_d    = out_item_q;
    out_valid_d   = out_valid_q && out_stall_i;

    if (pop_o) begin
      case (head_i.op)
        bls_pkg::OpLoad: begin
          cur_x_d       = head_i.start_x;
          cur_y_d       = head_i.start_y;
          target_x_d    = head_i.end_x;
          target_y_d    = head_i.end_y;
          delta_x_d     = head_i.delta_x;
          delta_y_mag_d = head_i.delta_y_mag;
          step_x_neg_d  = head_i.step_x_neg;
          step_y_neg_d  = head_i.step_y_neg;
          error_term_d  = head_i.error_init;
          line_active_d = 1'b1;
        end
        bls_pkg::OpStep: begin
          if (line_active_q) begin
            out_valid_d           = 1'b1;
            out_item_d.pixel_x    = cur_x_q;
            out_item_d.pixel_y    = cur_y_q;
            out_item_d.last_pixel = at_end;
            if (at_end) begin
              line_active_d = 1'b0;
            end else begin
              error_term_d = error_term_q - err_dy + err_dx;
              if (move_x) begin
                cur_x_d = step_x_neg_q ? cur_x_q - bls_pkg::coord_t'(1)
                                       : cur_x_q + bls_pkg::coord_t'(1);
              end
              if (move_y) begin
                cur_y_d = step_y_neg_q ? cur_y_q - bls_pkg::coord_t'(1)
                                       : cur_y_q + bls_pkg::coord_t'(1);
              end
            end
          end
        end
        default: begin
          line_active_d = line_active_q;
        end
      endcase
    end
  end

  // line state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q       <= '0;
      cur_y_q       <= '0;
      target_x_q    <= '0;
      target_y_q    <= '0;
      delta_x_q     <= '0;
      delta_y_mag_q <= '0;
      step_x_neg_q  <= 1'b0;
      step_y_neg_q  <= 1'b0;
      error_term_q  <= '0;
      line_active_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      cur_x_q       <= cur_x_d;
      cur_y_q       <= cur_y_d;
      target_x_q    <= target_x_d;
      target_y_q    <= target_y_d;
      delta_x_q     <= delta_x_d;
      delta_y_mag_q <= delta_y_mag_d;
      step_x_neg_q  <= step_x_neg_d;
      step_y_neg_q  <= step_y_neg_d;
      error_term_q  <= error_term_d;
      line_active_q <= line_active_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

endmodule

@@ src/bresenham_line_stepper.sv @@
// top level of the bresenham line stepper
// Draws integer Bresenham lines in all octants, one item per clock while nothing
// stalls. A load item sets up the deltas, step directions and error term and
// gives no result; each step item gives the current pixel, with last_pixel on the
// end point, and steps while idle give nothing. The front end accepts an item
// every cycle while the command queue (QUEUE_DEPTH entries) has room; the back end
// retires one command per cycle, a step as soon as the output register is free or
// being emptied. A step item is held in the command queue and its pixel in the
// output register; in_stall_o rises only when the queue fills.
module bresenham_line_stepper #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bls_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bls_pkg::out_item_t out_item_o
);

  bls_pkg::q_stat_t q_stat;
  bls_pkg::cmd_t    push_cmd;
  bls_pkg::cmd_t    head_cmd;
  logic             push;
  logic             pop;

  // accept and classify
  bls_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  // decoupling queue
  bls_cmd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head_cmd),
    .stat_o     (q_stat)
  );

  // line stepping and result register
  bls_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_cmd),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

@@ sim/bresenham_line_stepper_test.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the bresenham line stepper, with its own line tracer
module bresenham_line_stepper_test;

  localparam int CoordMin    = -(1 << (bls_pkg::CoordBits - 1));
  localparam int CoordMax    = (1 << (bls_pkg::CoordBits - 1)) - 1;
  localparam bls_pkg::coord_t CoordLo = bls_pkg::coord_t'(CoordMin);
  localparam bls_pkg::coord_t CoordHi = bls_pkg::coord_t'(CoordMax);
  localparam int CycleLimit  = 200000;
  localparam int HoldCycles  = 60;
  localparam int PhaseItems  = 175;
  localparam int NumPhases   = 6;
  localparam int DrainCycles = 5000;
  localparam int TailCycles  = 20;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  bls_pkg::in_item_t  in_item_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  bls_pkg::out_item_t out_item_o;

  // line items waiting to be offered, pixels waiting to come out
  bls_pkg::in_item_t  stim_items[$];
  bls_pkg::out_item_t pending_pixels[$];
  bls_pkg::out_item_t want_pixel;

  // handshakes seen at the last rising edge
  logic in_took  = 1'b0;
  logic out_took = 1'b0;

  // sender and receiver pacing
  logic        drive_busy     = 1'b0;
  int unsigned send_gap       = 0;
  int unsigned send_gap_max   = 0;
  int unsigned recv_wait      = 0;
  int unsigned recv_stall_max = 0;
  int unsigned hold_left      = 0;
  logic        hold_req       = 1'b0;

  int errors      = 0;
  int cycle_count = 0;
  int line_items  = 0;

  // tracer state of the line being drawn
  bls_pkg::coord_t pos_x    = '0;
  bls_pkg::coord_t pos_y    = '0;
  bls_pkg::coord_t end_pt_x = '0;
  bls_pkg::coord_t end_pt_y = '0;
  bls_pkg::mag_t   span_x   = '0;
  bls_pkg::mag_t   span_y   = '0;
  logic            x_down   = 1'b0;
  logic            y_down   = 1'b0;
  bls_pkg::err_t   err_acc  = '0;
  logic            drawing  = 1'b0;

  bresenham_line_stepper dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: run limit of %0d cycles reached", $time, CycleLimit);
      $display("[bresenham_line_stepper] ERROR");
      $finish;
    end
  end

  // trace one accepted item and queue the pixel it gives, if any
  function automatic void trace_line_item(bls_pkg::in_item_t it);
    int                 dx;
    int                 dy;
    int                 e2;
    bls_pkg::out_item_t px;
    if (it.op == bls_pkg::OpLoad) begin
      dx = int'(it.end_x) - int'(it.start_x);
      dy = int'(it.end_y) - int'(it.start_y);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      pos_x    = it.start_x;
      pos_y    = it.start_y;
      end_pt_x = it.end_x;
      end_pt_y = it.end_y;
      span_x   = bls_pkg::mag_t'(dx);
      span_y   = bls_pkg::mag_t'(dy);
      x_down   = !(it.start_x < it.end_x);
      y_down   = !(it.start_y < it.end_y);
      err_acc  = bls_pkg::err_t'(dx - dy);
      drawing  = 1'b1;
    end else if (drawing) begin
      px.pixel_x = pos_x;
      px.pixel_y = pos_y;
      if (pos_x == end_pt_x && pos_y == end_pt_y) begin
        px.last_pixel = 1'b1;
        drawing       = 1'b0;
      end else begin
        px.last_pixel = 1'b0;
        dx = int'(span_x);
        dy = int'(span_y);
        e2 = 2 * int'(err_acc);
        if (e2 >= -dy) begin
          err_acc = bls_pkg::err_t'(int'(err_acc) - dy);
          pos_x   = x_down ? bls_pkg::coord_t'(int'(pos_x) - 1)
                           : bls_pkg::coord_t'(int'(pos_x) + 1);
        end
        if (e2 <= dx) begin
          err_acc = bls_pkg::err_t'(int'(err_acc) + dx);
          pos_y   = y_down ? bls_pkg::coord_t'(int'(pos_y) - 1)
                           : bls_pkg::coord_t'(int'(pos_y) + 1);
        end
      end
      pending_pixels.push_back(px);
    end
  endfunction

  // monitor: check pixels and trace accepted items at the rising edge
  always @(posedge clk_i) begin
    in_took  = rst_ni && in_valid_i && !in_stall_o;
    out_took = rst_ni && out_valid_o && !out_stall_i;
    if (out_took) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: pixel with none expected: x=%0d y=%0d last=%0b", $time,
                 out_item_o.pixel_x, out_item_o.pixel_y, out_item_o.last_pixel);
        errors++;
      end else begin
        want_pixel = pending_pixels.pop_front();
        if (out_item_o.pixel_x !== want_pixel.pixel_x) begin
          $display("%0t: pixel_x expected %0d, actual %0d", $time,
                   want_pixel.pixel_x, out_item_o.pixel_x);
          errors++;
        end
        if (out_item_o.pixel_y !== want_pixel.pixel_y) begin
          $display("%0t: pixel_y expected %0d, actual %0d", $time,
                   want_pixel.pixel_y, out_item_o.pixel_y);
          errors++;
        end
        if (out_item_o.last_pixel !== want_pixel.last_pixel) begin
          $display("%0t: last_pixel expected %0b, actual %0b", $time,
                   want_pixel.last_pixel, out_item_o.last_pixel);
          errors++;
        end
      end
    end
    if (in_took) trace_line_item(in_item_i);
  end

  // driver: offer queued items at the falling edge with random gaps
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (drive_busy && in_took) begin
        drive_busy = 1'b0;
        send_gap   = $urandom_range(0, send_gap_max);
      end
      if (!drive_busy) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (stim_items.size() != 0) begin
          in_item_i  <= stim_items.pop_front();
          drive_busy = 1'b1;
        end
      end
      in_valid_i <= drive_busy;
    end
  end

  // receiver: random stall per pixel, plus one long hold on request
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_took) recv_wait = $urandom_range(0, recv_stall_max);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (recv_wait != 0) begin
        recv_wait--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic void queue_load(bls_pkg::coord_t sx, bls_pkg::coord_t sy,
                                     bls_pkg::coord_t ex, bls_pkg::coord_t ey);
    bls_pkg::in_item_t it;
    it.op      = bls_pkg::OpLoad;
    it.start_x = sx;
    it.start_y = sy;
    it.end_x   = ex;
    it.end_y   = ey;
    stim_items.push_back(it);
  endfunction

  // step item; its coordinate fields are don't-care, so fill them with noise
  function automatic void queue_step();
    bls_pkg::in_item_t it;
    it.op      = bls_pkg::OpStep;
    it.start_x = bls_pkg::coord_t'($urandom());
    it.start_y = bls_pkg::coord_t'($urandom());
    it.end_x   = bls_pkg::coord_t'($urandom());
    it.end_y   = bls_pkg::coord_t'($urandom());
    stim_items.push_back(it);
  endfunction

  function automatic int line_len(bls_pkg::coord_t sx, bls_pkg::coord_t sy,
                                  bls_pkg::coord_t ex, bls_pkg::coord_t ey);
    int dx;
    int dy;
    dx = int'(ex) - int'(sx);
    dy = int'(ey) - int'(sy);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return ((dx > dy) ? dx : dy) + 1;
  endfunction

  // load a line and follow it with a number of step items
  function automatic void queue_line(bls_pkg::coord_t sx, bls_pkg::coord_t sy,
                                     bls_pkg::coord_t ex, bls_pkg::coord_t ey,
                                     int steps);
    int len;
    len = line_len(sx, sy, ex, ey);
    queue_load(sx, sy, ex, ey);
    repeat (steps) queue_step();
    line_items += 1 + ((steps < len) ? steps : len);
  endfunction

  // mostly uniform, sometimes pinned to an edge of the range
  function automatic bls_pkg::coord_t rand_coord();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return CoordLo;
    if (pick == 1) return CoordHi;
    return bls_pkg::coord_t'($urandom());
  endfunction

  function automatic bls_pkg::coord_t near_coord(bls_pkg::coord_t base, int span);
    int v;
    v = int'(base) + int'($urandom_range(0, 2 * span)) - span;
    if (v < CoordMin) v = CoordMin;
    if (v > CoordMax) v = CoordMax;
    return bls_pkg::coord_t'(v);
  endfunction

  // hold new items back until everything queued so far is drawn
  task automatic pause_sender();
    while (stim_items.size() != 0 || drive_busy) @(posedge clk_i);
    while (pending_pixels.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    bls_pkg::coord_t sx;
    bls_pkg::coord_t sy;
    bls_pkg::coord_t ex;
    bls_pkg::coord_t ey;
    int              len;
    int              steps;
    int              span;
    int unsigned     span_sel;
    int unsigned     shape;
    int              phase;
    int              drain;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed lines
    send_gap_max   = 3;
    recv_stall_max = 3;
    queue_step();                                   // step while idle
    queue_load(0, 0, 0, 0);                         // start equals end
    queue_step();
    queue_step();
    queue_load(CoordLo, CoordLo, CoordHi, CoordHi);
    repeat (2) queue_step();
    queue_load(CoordHi, CoordHi, CoordLo, CoordLo);   // reload while drawing
    repeat (2) queue_step();
    queue_load(CoordHi, CoordLo, CoordLo, CoordHi);
    repeat (2) queue_step();
    queue_load(CoordLo, CoordHi, CoordHi, CoordLo);
    repeat (2) queue_step();
    queue_load(1, 7, 3, 7);                         // horizontal, y never steps
    repeat (3) queue_step();
    queue_load(4, 1, 4, -1);                        // vertical, x never steps
    repeat (3) queue_step();
    pause_sender();

    // random lines in phases of different pacing
    for (phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: begin send_gap_max = 0; recv_stall_max = 0; end
        1: begin send_gap_max = 0; recv_stall_max = 7; hold_req = 1'b1; end
        2: begin send_gap_max = 7; recv_stall_max = 7; end
        3: begin send_gap_max = 7; recv_stall_max = 0; end
        4: begin send_gap_max = 0; recv_stall_max = 7; end
        default: begin send_gap_max = 3; recv_stall_max = 5; end
      endcase
      line_items = 0;
      while (line_items < PhaseItems) begin
        sx       = rand_coord();
        sy       = rand_coord();
        span_sel = $urandom_range(0, 15);
        span     = (span_sel == 0) ? 0 : (span_sel < 3) ? 2 : (span_sel < 15) ? 15 : 60;
        shape    = $urandom_range(0, 9);
        if (shape == 9) begin
          // far endpoints, cut off early by the next load
          ex    = rand_coord();
          ey    = rand_coord();
          steps = $urandom_range(0, 4);
        end else begin
          ex  = near_coord(sx, span);
          ey  = near_coord(sy, span);
          len = line_len(sx, sy, ex, ey);
          if (shape == 8) steps = $urandom_range(0, len - 1);
          else steps = len + $urandom_range(0, 2);
        end
        queue_line(sx, sy, ex, ey, steps);
      end
      pause_sender();
    end

    // wind down
    while (stim_items.size() != 0 || drive_busy) @(posedge clk_i);
    drain = 0;
    while (pending_pixels.size() != 0 && drain < DrainCycles) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (TailCycles) @(posedge clk_i);
    if (pending_pixels.size() != 0) begin
      $display("%0t: %0d expected pixels never came out", $time, pending_pixels.size());
      errors++;
    end
    if (errors == 0) begin
      $display("[bresenham_line_stepper] OK");
    end else begin
      $display("[bresenham_line_stepper] ERROR");
    end
    $finish;
  end

endmodule
